### src/mcbs_pkg.sv
// mcbs_pkg: shared types and constants of the mip chain byte size block
// no dependencies; imported by every module of the block
`default_nettype none

package mcbs_pkg;

	// default widths of the base level dimensions (the port carries one bit more)
	localparam int unsigned DIM_BITS_DEF   = 14;
	localparam int unsigned DEPTH_BITS_DEF = 11;

	// fixed widths of the result and of the register file
	localparam int unsigned OUT_W     = 44;
	localparam int unsigned LVL_W     = 4;
	localparam int unsigned EB_W      = 5;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes on the write port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_COMPRESSED = 1'b0,
		CFG_ELEMENT_BYTES    = 1'b1
	} cfg_idx_t;

	// live register contents
	typedef struct packed {
		logic            block_compressed;
		logic [EB_W-1:0] element_bytes;
	} cfg_t;

	// operand width of the shared multiplier: a full w*h product, and at least 32 bits
	function automatic int unsigned mul_a_width(input int unsigned dim_bits);
		return (2 * (dim_bits + 1) > 32) ? 2 * (dim_bits + 1) : 32;
	endfunction

	// second operand: a dimension, a depth or the bytes per element
	function automatic int unsigned mul_b_width(input int unsigned dim_bits,
			input int unsigned depth_bits);
		int unsigned w;
		w = dim_bits + 1;
		if (depth_bits + 1 > w)
			w = depth_bits + 1;
		if (EB_W > w)
			w = EB_W;
		return w;
	endfunction

endpackage

`default_nettype wire

### src/mip_chain_byte_size_core.sv
// mip_chain_byte_size_core: top level, register file and result ports
// depends on mcbs_pkg, mcbs_mul and mcbs_ctrl
`default_nettype none

// Byte size of a range of mip levels. A query is taken when start is high and
// busy is low; the answer appears on byte_count and levels_counted for a single
// cycle marked by done, once every level of the range has been summed and the sum
// has been scaled by the element size. There is no back-pressure on the
// answer: done must be sampled in that cycle. The time is set by one shared
// multiplier that is used twice per level (width times height, then times
// depth or by one in block mode) and twice more to scale by the element size.
// A new query may be taken in the cycle in which done is high. Registers are
// written through cfg_we, cfg_index and cfg_data and must only change while
// busy is low; depth 0 marks a cube map and counts six faces.
module mip_chain_byte_size_core #(
	parameter int unsigned DIM_BITS   = mcbs_pkg::DIM_BITS_DEF,
	parameter int unsigned DEPTH_BITS = mcbs_pkg::DEPTH_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mcbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mcbs_pkg::EB_W-1:0]        cfg_data,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [DIM_BITS:0]                width,
	input  wire logic [DIM_BITS:0]                height,
	input  wire logic [DEPTH_BITS:0]              depth,
	input  wire logic [mcbs_pkg::LVL_W-1:0]       first_level,
	input  wire logic [mcbs_pkg::LVL_W-1:0]       level_count,
	output logic                                  done,
	output logic [mcbs_pkg::OUT_W-1:0]            byte_count,
	output logic [mcbs_pkg::LVL_W-1:0]            levels_counted
);
	import mcbs_pkg::*;

	localparam int unsigned MA_W   = mul_a_width(DIM_BITS);
	localparam int unsigned MB_W   = mul_b_width(DIM_BITS, DEPTH_BITS);
	localparam int unsigned PROD_W = MA_W + MB_W;

	cfg_t               cfg_q;
	logic               mul_en;
	logic [MA_W-1:0]    mul_a;
	logic [MB_W-1:0]    mul_b;
	logic [PROD_W-1:0]  prod;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_compressed <= 1'b0;
			cfg_q.element_bytes    <= EB_W'(4);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BLOCK_COMPRESSED: cfg_q.block_compressed <= cfg_data[0];
				CFG_ELEMENT_BYTES:    cfg_q.element_bytes    <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// level walk and scaling sequencer
	mcbs_ctrl #(
		.DIM_BITS   (DIM_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.width          (width),
		.height         (height),
		.depth          (depth),
		.first_level    (first_level),
		.level_count    (level_count),
		.cfg            (cfg_q),
		.prod           (prod),
		.mul_en         (mul_en),
		.mul_a          (mul_a),
		.mul_b          (mul_b),
		.busy           (busy),
		.done           (done),
		.byte_count     (byte_count),
		.levels_counted (levels_counted)
	);

	// shared multiplier
	mcbs_mul #(
		.DIM_BITS   (DIM_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

endmodule

`default_nettype wire

### src/mcbs_mul.sv
// mcbs_mul: shared unsigned multiplier with a registered product
// depends on mcbs_pkg for the operand widths
`default_nettype none

module mcbs_mul #(
	parameter int unsigned DIM_BITS   = mcbs_pkg::DIM_BITS_DEF,
	parameter int unsigned DEPTH_BITS = mcbs_pkg::DEPTH_BITS_DEF
) (
	input  wire logic                                           clk,
	input  wire logic                                           en,
	input  wire logic [mcbs_pkg::mul_a_width(DIM_BITS)-1:0]     a,
	input  wire logic [mcbs_pkg::mul_b_width(DIM_BITS, DEPTH_BITS)-1:0] b,
	output logic [mcbs_pkg::mul_a_width(DIM_BITS)
		+ mcbs_pkg::mul_b_width(DIM_BITS, DEPTH_BITS)-1:0]       prod
);
	import mcbs_pkg::*;

	localparam int unsigned MA_W   = mul_a_width(DIM_BITS);
	localparam int unsigned MB_W   = mul_b_width(DIM_BITS, DEPTH_BITS);
	localparam int unsigned PROD_W = MA_W + MB_W;

	logic [PROD_W-1:0] prod_q;

	// product register, loaded whenever the sequencer issues operands
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

### src/mcbs_ctrl.sv
// mcbs_ctrl: level walk sequencer, accumulator and final scaling
// depends on mcbs_pkg; drives the shared multiplier mcbs_mul
`default_nettype none

module mcbs_ctrl #(
	parameter int unsigned DIM_BITS   = mcbs_pkg::DIM_BITS_DEF,
	parameter int unsigned DEPTH_BITS = mcbs_pkg::DEPTH_BITS_DEF
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           start,
	input  wire logic [DIM_BITS:0]                              width,
	input  wire logic [DIM_BITS:0]                              height,
	input  wire logic [DEPTH_BITS:0]                            depth,
	input  wire logic [mcbs_pkg::LVL_W-1:0]                     first_level,
	input  wire logic [mcbs_pkg::LVL_W-1:0]                     level_count,
	input  wire mcbs_pkg::cfg_t                                 cfg,
	input  wire logic [mcbs_pkg::mul_a_width(DIM_BITS)
		+ mcbs_pkg::mul_b_width(DIM_BITS, DEPTH_BITS)-1:0]       prod,
	output logic                                                mul_en,
	output logic [mcbs_pkg::mul_a_width(DIM_BITS)-1:0]          mul_a,
	output logic [mcbs_pkg::mul_b_width(DIM_BITS, DEPTH_BITS)-1:0] mul_b,
	output logic                                                busy,
	output logic                                                done,
	output logic [mcbs_pkg::OUT_W-1:0]                          byte_count,
	output logic [mcbs_pkg::LVL_W-1:0]                          levels_counted
);
	import mcbs_pkg::*;

	localparam int unsigned DW     = DIM_BITS + 1;
	localparam int unsigned DDW    = DEPTH_BITS + 1;
	localparam int unsigned MA_W   = mul_a_width(DIM_BITS);
	localparam int unsigned MB_W   = mul_b_width(DIM_BITS, DEPTH_BITS);
	localparam int unsigned PROD_W = MA_W + MB_W;
	localparam int unsigned ACC_W  = 2 * MA_W + 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LVL_A,
		ST_LVL_B,
		ST_FIN_ACC,
		ST_FIN_CUBE,
		ST_FIN_LO,
		ST_FIN_HI,
		ST_FIN_ADD
	} state_t;

	state_t             state_q;
	logic [DW-1:0]      w_q, h_q;
	logic [DDW-1:0]     d_q;
	logic [LVL_W-1:0]   cnt_q;
	logic               all_q;
	logic               cube_q;
	logic               blocks_q;
	logic               pend_q;
	logic [LVL_W-1:0]   levels_q;
	logic [ACC_W-1:0]   acc_q;
	logic               done_q;
	logic [OUT_W-1:0]   byte_count_q;

	logic [DW-1:0]      w_sh, h_sh, w_init, h_init;
	logic [DDW-1:0]     d_base, d_sh, d_init;
	logic [DW-1:0]      nw, nh;
	logic [DDW-1:0]     nd;
	logic               all_zero, last_lvl;
	logic [DW:0]        w_rnd, h_rnd;
	logic [ACC_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   total;

	// base dimensions at the first counted level, zero counts as one
	always_comb begin
		w_sh   = width >> first_level;
		h_sh   = height >> first_level;
		d_base = cfg.block_compressed ? DDW'(1) : depth;
		d_sh   = d_base >> first_level;
		w_init = (w_sh == '0) ? DW'(1) : w_sh;
		h_init = (h_sh == '0) ? DW'(1) : h_sh;
		d_init = (d_sh == '0) ? DDW'(1) : d_sh;
	end

	// next level and the stop test
	always_comb begin
		nw       = w_q >> 1;
		nh       = h_q >> 1;
		nd       = d_q >> 1;
		all_zero = (nw == '0) && (nh == '0) && (nd == '0);
		last_lvl = all_zero || (!all_q && cnt_q == LVL_W'(1));
	end

	// 4x4 block counts, rounded up
	always_comb begin
		w_rnd = ({1'b0, w_q} + (DW + 1)'(3)) >> 2;
		h_rnd = ({1'b0, h_q} + (DW + 1)'(3)) >> 2;
	end

	// accumulator plus the last product, and the final total
	always_comb begin
		acc_sum = acc_q + ACC_W'(prod);
		total   = acc_q + (ACC_W'(prod) << MA_W);
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_LVL_A: begin
				mul_en = 1'b1;
				mul_a  = blocks_q ? MA_W'(w_rnd) : MA_W'(w_q);
				mul_b  = blocks_q ? MB_W'(h_rnd) : MB_W'(h_q);
			end
			ST_LVL_B: begin
				mul_en = 1'b1;
				mul_a  = prod[MA_W-1:0];
				mul_b  = MB_W'(d_q);
			end
			ST_FIN_LO: begin
				mul_en = 1'b1;
				mul_a  = acc_q[MA_W-1:0];
				mul_b  = MB_W'(cfg.element_bytes);
			end
			ST_FIN_HI: begin
				mul_en = 1'b1;
				mul_a  = acc_q[2*MA_W-1:MA_W];
				mul_b  = MB_W'(cfg.element_bytes);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// sequencer, walk state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			w_q          <= '0;
			h_q          <= '0;
			d_q          <= '0;
			cnt_q        <= '0;
			all_q        <= 1'b0;
			cube_q       <= 1'b0;
			blocks_q     <= 1'b0;
			pend_q       <= 1'b0;
			levels_q     <= '0;
			acc_q        <= '0;
			done_q       <= 1'b0;
			byte_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						w_q      <= w_init;
						h_q      <= h_init;
						d_q      <= d_init;
						cnt_q    <= level_count;
						all_q    <= (level_count == '0);
						cube_q   <= (depth == '0);
						blocks_q <= cfg.block_compressed;
						pend_q   <= 1'b0;
						levels_q <= '0;
						acc_q    <= '0;
						state_q  <= ST_LVL_A;
					end
				end
				ST_LVL_A: begin
					// fold in the previous level's product while w*h is formed
					if (pend_q) begin
						acc_q <= acc_sum;
					end
					state_q <= ST_LVL_B;
				end
				ST_LVL_B: begin
					levels_q <= levels_q + LVL_W'(1);
					if (last_lvl) begin
						state_q <= ST_FIN_ACC;
					end else begin
						w_q     <= (nw == '0) ? DW'(1) : nw;
						h_q     <= (nh == '0) ? DW'(1) : nh;
						d_q     <= (nd == '0) ? DDW'(1) : nd;
						cnt_q   <= cnt_q - LVL_W'(1);
						pend_q  <= 1'b1;
						state_q <= ST_LVL_A;
					end
				end
				ST_FIN_ACC: begin
					acc_q   <= acc_sum;
					state_q <= ST_FIN_CUBE;
				end
				ST_FIN_CUBE: begin
					// six faces as four plus two
					if (cube_q) begin
						acc_q <= (acc_q << 2) + (acc_q << 1);
					end
					state_q <= ST_FIN_LO;
				end
				ST_FIN_LO: begin
					state_q <= ST_FIN_HI;
				end
				ST_FIN_HI: begin
					// low partial product moves to the accumulator
					acc_q   <= ACC_W'(prod);
					state_q <= ST_FIN_ADD;
				end
				ST_FIN_ADD: begin
					// add the high partial product and saturate
					byte_count_q <= (|total[ACC_W-1:OUT_W]) ? '1 : total[OUT_W-1:0];
					done_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign byte_count     = byte_count_q;
	assign levels_counted = levels_q;

endmodule

`default_nettype wire
